/* sv/rrwt_pkg.sv */
// ----------------------------------------------------------------------------
// rrwt_pkg
// Shared sizes, register map and controller state type for the round-robin
// waiting time calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package rrwt_pkg;

  // job store sizing
  localparam int MAX_JOBS   = 16;
  localparam int BURST_BITS = 16;
  localparam int IDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);

  // fixed field widths
  localparam int BURST_IN_W = 16;
  localparam int QUANTUM_W  = 16;
  localparam int JOB_W      = 4;
  localparam int TIME_W     = 20;
  localparam int TOT_W      = 24;

  // width used when comparing remaining time against the quantum
  localparam int RQ_W = (BURST_BITS > QUANTUM_W) ? BURST_BITS : QUANTUM_W;

  // remaining/wait memory word: {remaining, wait}
  localparam int RW_W = BURST_BITS + TIME_W;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = CFG_IDX_W'(0);
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = QUANTUM_W'(4);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_OUT_RD,
    ST_OUT_EMIT
  } rrwt_state_t;

endpackage

`default_nettype wire

/* sv/rrwt_ram.sv */
// ----------------------------------------------------------------------------
// rrwt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrwt_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/rrwt_cfg.sv */
// ----------------------------------------------------------------------------
// rrwt_cfg
// APB-style configuration register block holding the scheduling quantum.
// ----------------------------------------------------------------------------
`default_nettype none

module rrwt_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rrwt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rrwt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rrwt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [rrwt_pkg::QUANTUM_W-1:0]  quantum
);
  import rrwt_pkg::*;

  logic [QUANTUM_W-1:0] quantum_r;
  logic [QUANTUM_W-1:0] quantum_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_beat;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_beat = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign quantum = quantum_r;

  // register write decode
  always_comb begin
    quantum_nxt = quantum_r;
    if (wr_beat && (reg_idx == REG_QUANTUM)) begin
      quantum_nxt = pwdata[QUANTUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else begin
      quantum_r <= quantum_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_QUANTUM) begin
      prdata = CFG_DATA_W'(quantum_r);
    end
  end

endmodule

`default_nettype wire

/* sv/rrwt_ctrl.sv */
// ----------------------------------------------------------------------------
// rrwt_ctrl
// Load, round-robin walk and result sequencer; reads, updates and writes back
// the job memories one entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rrwt_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rrwt_pkg::QUANTUM_W-1:0]  quantum,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rrwt_pkg::BURST_IN_W-1:0] in_burst_time,
  input  wire logic                            in_last_job,
  // burst memory
  output logic                                 bm_we,
  output logic      [rrwt_pkg::IDX_W-1:0]      bm_waddr,
  output logic      [rrwt_pkg::BURST_BITS-1:0] bm_wdata,
  output logic      [rrwt_pkg::IDX_W-1:0]      bm_raddr,
  input  wire logic [rrwt_pkg::BURST_BITS-1:0] bm_rdata,
  // remaining/wait memory
  output logic                                 rw_we,
  output logic      [rrwt_pkg::IDX_W-1:0]      rw_waddr,
  output logic      [rrwt_pkg::RW_W-1:0]       rw_wdata,
  output logic      [rrwt_pkg::IDX_W-1:0]      rw_raddr,
  input  wire logic [rrwt_pkg::RW_W-1:0]       rw_rdata,
  // results
  output logic                                 out_valid,
  output logic      [rrwt_pkg::JOB_W-1:0]      out_job_index,
  output logic      [rrwt_pkg::TIME_W-1:0]     out_waiting_time,
  output logic      [rrwt_pkg::TIME_W-1:0]     out_turnaround_time,
  output logic      [rrwt_pkg::TOT_W-1:0]      out_total_waiting,
  output logic      [rrwt_pkg::TOT_W-1:0]      out_total_turnaround,
  output logic                                 out_last_result
);
  import rrwt_pkg::*;

  rrwt_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TOT_W-1:0]  tw_r, tw_nxt;
  logic [TOT_W-1:0]  tt_r, tt_nxt;

  logic              ov_r, ov_nxt;
  logic [JOB_W-1:0]  oidx_r, oidx_nxt;
  logic [TIME_W-1:0] ow_r, ow_nxt;
  logic [TIME_W-1:0] ot_r, ot_nxt;
  logic [TOT_W-1:0]  otw_r, otw_nxt;
  logic [TOT_W-1:0]  ott_r, ott_nxt;
  logic              olast_r, olast_nxt;

  logic                  accept;
  logic                  full;
  logic                  at_end;
  logic [RQ_W-1:0]       q_eff;
  logic [BURST_BITS-1:0] rem;
  logic [TIME_W-1:0]     wait_rd;
  logic [RQ_W-1:0]       rem_ext;
  logic                  rem_nz;
  logic                  over_q;
  logic [TIME_W-1:0]     time_add;
  logic [TIME_W-1:0]     w_calc;
  logic [TIME_W-1:0]     t_calc;
  logic [BURST_BITS-1:0] burst_in;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;
  assign full     = (count_r == CNT_W'(MAX_JOBS));
  assign at_end   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign burst_in = BURST_BITS'(in_burst_time);

  // quantum of zero counts as one
  assign q_eff = (quantum == '0) ? RQ_W'(1) : RQ_W'(quantum);

  // memory word fields
  assign rem     = rw_rdata[RW_W-1:TIME_W];
  assign wait_rd = rw_rdata[TIME_W-1:0];
  assign rem_ext = RQ_W'(rem);
  assign rem_nz  = (rem != '0);
  assign over_q  = (rem_ext > q_eff);

  // one turn of service
  assign time_add = over_q ? TIME_W'(time_r + TIME_W'(q_eff))
                           : TIME_W'(time_r + TIME_W'(rem_ext));
  assign w_calc   = TIME_W'(time_add - TIME_W'(bm_rdata));

  // turnaround from stored wait
  assign t_calc = TIME_W'(TIME_W'(bm_rdata) + wait_rd);

  // read addresses follow the walk index
  assign bm_raddr = idx_r;
  assign rw_raddr = idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last_job) begin
          state_nxt = ST_RUN_RD;
        end
      end
      ST_RUN_RD: begin
        state_nxt = ST_RUN_WR;
      end
      ST_RUN_WR: begin
        if (at_end && !(pend_r || rem_nz)) begin
          state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = ST_RUN_RD;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    time_nxt  = time_r;
    tw_nxt    = tw_r;
    tt_nxt    = tt_r;
    ov_nxt    = 1'b0;
    oidx_nxt  = oidx_r;
    ow_nxt    = ow_r;
    ot_nxt    = ot_r;
    otw_nxt   = otw_r;
    ott_nxt   = ott_r;
    olast_nxt = olast_r;
    bm_we     = 1'b0;
    bm_waddr  = count_r[IDX_W-1:0];
    bm_wdata  = burst_in;
    rw_we     = 1'b0;
    rw_waddr  = count_r[IDX_W-1:0];
    rw_wdata  = {burst_in, TIME_W'(0)};
    case (state_r)
      ST_IDLE: begin
        // load a job: remaining starts at the burst, wait at zero
        if (accept) begin
          if (!full) begin
            bm_we     = 1'b1;
            rw_we     = 1'b1;
            count_nxt = CNT_W'(count_r + CNT_W'(1));
          end
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          time_nxt = '0;
        end
      end
      ST_RUN_RD: begin
      end
      ST_RUN_WR: begin
        // serve the job once and write it back
        rw_waddr = idx_r;
        if (rem_nz) begin
          rw_we    = 1'b1;
          pend_nxt = 1'b1;
          time_nxt = time_add;
          if (over_q) begin
            rw_wdata = {BURST_BITS'(rem_ext - q_eff), wait_rd};
          end else begin
            rw_wdata = {BURST_BITS'(0), w_calc};
          end
        end
        if (at_end) begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          tw_nxt   = '0;
          tt_nxt   = '0;
        end else begin
          idx_nxt = IDX_W'(idx_r + IDX_W'(1));
        end
      end
      ST_OUT_RD: begin
      end
      ST_OUT_EMIT: begin
        // one result beat per job with running totals
        tw_nxt    = TOT_W'(tw_r + TOT_W'(wait_rd));
        tt_nxt    = TOT_W'(tt_r + TOT_W'(t_calc));
        ov_nxt    = 1'b1;
        oidx_nxt  = JOB_W'(idx_r);
        ow_nxt    = wait_rd;
        ot_nxt    = t_calc;
        otw_nxt   = tw_nxt;
        ott_nxt   = tt_nxt;
        olast_nxt = at_end;
        if (at_end) begin
          count_nxt = '0;
          idx_nxt   = '0;
        end else begin
          idx_nxt = IDX_W'(idx_r + IDX_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      time_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      time_r  <= time_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // totals and result payload
  always_ff @(posedge clk) begin
    tw_r    <= tw_nxt;
    tt_r    <= tt_nxt;
    oidx_r  <= oidx_nxt;
    ow_r    <= ow_nxt;
    ot_r    <= ot_nxt;
    otw_r   <= otw_nxt;
    ott_r   <= ott_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid            = ov_r;
  assign out_job_index        = oidx_r;
  assign out_waiting_time     = ow_r;
  assign out_turnaround_time  = ot_r;
  assign out_total_waiting    = otw_r;
  assign out_total_turnaround = ott_r;
  assign out_last_result      = olast_r;

endmodule

`default_nettype wire

/* sv/round_robin_wait_time_calc_top.sv */
// ----------------------------------------------------------------------------
// round_robin_wait_time_calc_top
// Round-robin scheduling waiting time calculator with APB-style quantum
// register.
// ----------------------------------------------------------------------------
// Jobs load one burst per cycle while busy is low (start with in_burst_time);
// the beat with in_last_job set starts the round-robin walk over the stored
// jobs. Each job visit takes a memory read state, then an update/write back
// state, for every visit of every pass including a final pass that finds all
// jobs done. Results then stream out in load order, one per read and emit
// state pair, each held on out_* for a single cycle under out_valid with no
// way to stall. busy stays high from the last-job beat until the final
// result is registered. At most 16 jobs are kept; further bursts of a set
// are dropped. The quantum register sits at byte address 0; zero acts as
// one.
`default_nettype none

module round_robin_wait_time_calc_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rrwt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rrwt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rrwt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  // job input
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rrwt_pkg::BURST_IN_W-1:0] in_burst_time,
  input  wire logic                            in_last_job,
  // results
  output logic                                 out_valid,
  output logic      [rrwt_pkg::JOB_W-1:0]      out_job_index,
  output logic      [rrwt_pkg::TIME_W-1:0]     out_waiting_time,
  output logic      [rrwt_pkg::TIME_W-1:0]     out_turnaround_time,
  output logic      [rrwt_pkg::TOT_W-1:0]      out_total_waiting,
  output logic      [rrwt_pkg::TOT_W-1:0]      out_total_turnaround,
  output logic                                 out_last_result
);
  import rrwt_pkg::*;

  logic [QUANTUM_W-1:0]  quantum;
  logic                  bm_we;
  logic [IDX_W-1:0]      bm_waddr;
  logic [BURST_BITS-1:0] bm_wdata;
  logic [IDX_W-1:0]      bm_raddr;
  logic [BURST_BITS-1:0] bm_rdata;
  logic                  rw_we;
  logic [IDX_W-1:0]      rw_waddr;
  logic [RW_W-1:0]       rw_wdata;
  logic [IDX_W-1:0]      rw_raddr;
  logic [RW_W-1:0]       rw_rdata;

  // quantum register
  rrwt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quantum (quantum)
  );

  // burst times in load order
  rrwt_ram #(
    .WIDTH  (BURST_BITS),
    .DEPTH  (MAX_JOBS),
    .ADDR_W (IDX_W)
  ) u_burst_mem (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // remaining time and waiting time per job
  rrwt_ram #(
    .WIDTH  (RW_W),
    .DEPTH  (MAX_JOBS),
    .ADDR_W (IDX_W)
  ) u_rw_mem (
    .clk   (clk),
    .we    (rw_we),
    .waddr (rw_waddr),
    .wdata (rw_wdata),
    .raddr (rw_raddr),
    .rdata (rw_rdata)
  );

  // sequencer and datapath
  rrwt_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .quantum              (quantum),
    .start                (start),
    .busy                 (busy),
    .in_burst_time        (in_burst_time),
    .in_last_job          (in_last_job),
    .bm_we                (bm_we),
    .bm_waddr             (bm_waddr),
    .bm_wdata             (bm_wdata),
    .bm_raddr             (bm_raddr),
    .bm_rdata             (bm_rdata),
    .rw_we                (rw_we),
    .rw_waddr             (rw_waddr),
    .rw_wdata             (rw_wdata),
    .rw_raddr             (rw_raddr),
    .rw_rdata             (rw_rdata),
    .out_valid            (out_valid),
    .out_job_index        (out_job_index),
    .out_waiting_time     (out_waiting_time),
    .out_turnaround_time  (out_turnaround_time),
    .out_total_waiting    (out_total_waiting),
    .out_total_turnaround (out_total_turnaround),
    .out_last_result      (out_last_result)
  );

endmodule

`default_nettype wire
